[rtl/core/twlp_pkg.sv]
// ----------------------------------------------------------------------------
// twlp_pkg
// Shared types and character constants for the word and link parser
// ----------------------------------------------------------------------------
package twlp_pkg;

  typedef enum logic [1:0] {
    FL_OUT   = 2'd0,
    FL_IN    = 2'd1,
    FL_AFTER = 2'd2
  } flow_t;

  typedef enum logic [3:0] {
    LK_OPEN_BR   = 4'd0,
    LK_TEXT      = 4'd1,
    LK_CLOSE_BR  = 4'd2,
    LK_OPEN_PAR  = 4'd3,
    LK_URL       = 4'd4,
    LK_URL_END   = 4'd5,
    LK_CLOSE_PAR = 4'd6,
    LK_WR_URL    = 4'd7,
    LK_WR_TEXT   = 4'd8,
    LK_OFF       = 4'd9
  } link_t;

  typedef enum logic [2:0] {
    MK_NONE      = 3'd0,
    MK_CHAR      = 3'd1,
    MK_SPACE     = 3'd2,
    MK_SPACE_URL = 3'd3,
    MK_URL       = 3'd4,
    MK_TEXT      = 3'd5,
    MK_END       = 3'd6
  } mark_t;

  localparam logic [1:0] KIND_FORCED = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    flow_t flow;
    link_t link;
  } ctl_t;

  typedef struct packed {
    logic text_first;
    logic text_last;
    logic url_first;
    logic url_last;
    logic link_after;
  } span_we_t;

endpackage

[rtl/core/twlp_step.sv]
// ----------------------------------------------------------------------------
// twlp_step
// Per-item decision logic: word flow, link recognition and replay steering
// ----------------------------------------------------------------------------
module twlp_step import twlp_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic [7:0]           ch,
  input  logic [POS_WIDTH-1:0] pos,
  input  logic [1:0]           kind,
  input  ctl_t                 ctl,
  input  logic [POS_WIDTH-1:0] text_first,
  input  logic [POS_WIDTH-1:0] text_last,
  input  logic [POS_WIDTH-1:0] url_first,
  input  logic [POS_WIDTH-1:0] url_last,
  input  logic [POS_WIDTH-1:0] link_after,
  output ctl_t                 ctl_next,
  output span_we_t             span_we,
  output logic [POS_WIDTH-1:0] pos_inc,
  output mark_t                mark,
  output logic [POS_WIDTH-1:0] resume_pos,
  output logic                 consumed
);

  logic blank;
  logic word;

  assign pos_inc = pos + {{(POS_WIDTH-1){1'b0}}, 1'b1};
  assign blank   = (ch == CH_SPACE) || (ch == CH_TAB);
  assign word    = !blank && (ch != CH_LF);

  always_comb begin
    ctl_next   = ctl;
    span_we    = '0;
    mark       = MK_NONE;
    resume_pos = pos_inc;
    consumed   = 1'b1;
    if (ctl.link != LK_OFF) begin
      consumed = 1'b0;
      if (kind == KIND_FORCED) begin
        ctl_next.link = LK_OFF;
        resume_pos    = pos;
      end else if (kind == KIND_END || ch == CH_LF) begin
        ctl_next.link = LK_OFF;
        resume_pos    = '0;
      end else begin
        unique case (ctl.link) inside
          LK_OPEN_BR: begin
            if (ch == CH_LBRACK) begin
              ctl_next.link = LK_TEXT;
            end else begin
              ctl_next.link = LK_OFF;
              resume_pos    = '0;
            end
          end
          LK_TEXT: begin
            if (!blank) begin
              ctl_next.link      = LK_CLOSE_BR;
              span_we.text_first = 1'b1;
            end
          end
          LK_CLOSE_BR: begin
            if (ch == CH_RBRACK) begin
              ctl_next.link     = LK_OPEN_PAR;
              span_we.text_last = 1'b1;
            end
          end
          LK_OPEN_PAR: begin
            if (ch == CH_LPAREN) begin
              ctl_next.link = LK_URL;
            end else begin
              ctl_next.link = LK_OFF;
              resume_pos    = '0;
            end
          end
          LK_URL: begin
            if (!blank) begin
              ctl_next.link     = LK_URL_END;
              span_we.url_first = 1'b1;
            end
          end
          LK_URL_END, LK_CLOSE_PAR: begin
            if (ch == CH_RPAREN) begin
              if (ctl.link == LK_URL_END) begin
                span_we.url_last = 1'b1;
              end
              // closing paren: enter the word first, then replay the url
              if (ctl.flow == FL_OUT) begin
                ctl_next.flow = FL_IN;
                resume_pos    = pos;
              end else begin
                mark               = (ctl.flow == FL_AFTER) ? MK_SPACE_URL : MK_URL;
                ctl_next.flow      = FL_IN;
                ctl_next.link      = LK_WR_URL;
                span_we.link_after = 1'b1;
                resume_pos         = url_first;
              end
            end else if (ctl.link == LK_URL_END) begin
              if (ch == CH_SPACE) begin
                ctl_next.link    = LK_CLOSE_PAR;
                span_we.url_last = 1'b1;
              end
            end else if (!blank) begin
              ctl_next.link = LK_OFF;
              resume_pos    = '0;
            end
          end
          LK_WR_URL: begin
            if (pos == url_last) begin
              mark          = MK_TEXT;
              ctl_next.link = LK_WR_TEXT;
              resume_pos    = text_first;
            end else begin
              mark = MK_CHAR;
            end
          end
          LK_WR_TEXT: begin
            if (pos == text_last) begin
              mark          = MK_END;
              ctl_next.link = LK_OPEN_BR;
              resume_pos    = link_after;
              consumed      = 1'b1;
            end else begin
              mark = MK_CHAR;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (kind != KIND_END) begin
      if (ctl.flow == FL_IN) begin
        if (word) begin
          mark = MK_CHAR;
        end else begin
          ctl_next.flow = FL_AFTER;
          ctl_next.link = LK_OPEN_BR;
        end
      end else if (word) begin
        if (ctl.flow == FL_AFTER) begin
          mark = MK_SPACE;
        end
        ctl_next.flow = FL_IN;
        consumed      = 1'b0;
        resume_pos    = pos;
      end
    end
  end

endmodule

[rtl/core/text_word_and_link_parser_top.sv]
// ----------------------------------------------------------------------------
// text_word_and_link_parser_top
// Word splitter with [text](url) link recognition and replay steering
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  input   | in_valid / in_stall  | ch, char_pos, char_kind
//  output  | out_valid / out_stall| mark, resume_pos, consumed
//
//  one item per cycle while the result register is not stalled
//  an input register feeds one level of decision logic into the result register
//  rst is synchronous: parser state returns to outside a word, expecting '['
//  an item waits in the input register while the result register is stalled
// ----------------------------------------------------------------------------
module text_word_and_link_parser_top import twlp_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           ch,
  input  logic [POS_WIDTH-1:0] char_pos,
  input  logic [1:0]           char_kind,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           mark,
  output logic [POS_WIDTH-1:0] resume_pos,
  output logic                 consumed
);

  logic                 in_vld;
  logic [7:0]           in_ch;
  logic [POS_WIDTH-1:0] in_pos;
  logic [1:0]           in_kind;
  logic                 adv;

  ctl_t                 ctl;
  ctl_t                 ctl_next;
  span_we_t             span_we;
  logic [POS_WIDTH-1:0] text_first;
  logic [POS_WIDTH-1:0] text_last;
  logic [POS_WIDTH-1:0] url_first;
  logic [POS_WIDTH-1:0] url_last;
  logic [POS_WIDTH-1:0] link_after;
  logic [POS_WIDTH-1:0] pos_inc;

  mark_t                mark_next;
  logic [POS_WIDTH-1:0] resume_pos_next;
  logic                 consumed_next;
  mark_t                out_mark;

  assign adv      = in_vld && (!out_valid || !out_stall);
  assign in_stall = in_vld && !adv;
  assign mark     = out_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_ch   <= ch;
      in_pos  <= char_pos;
      in_kind <= char_kind;
    end
  end

  twlp_step #(
    .POS_WIDTH(POS_WIDTH)
  ) u_step (
    .ch         (in_ch),
    .pos        (in_pos),
    .kind       (in_kind),
    .ctl        (ctl),
    .text_first (text_first),
    .text_last  (text_last),
    .url_first  (url_first),
    .url_last   (url_last),
    .link_after (link_after),
    .ctl_next   (ctl_next),
    .span_we    (span_we),
    .pos_inc    (pos_inc),
    .mark       (mark_next),
    .resume_pos (resume_pos_next),
    .consumed   (consumed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.flow <= FL_OUT;
      ctl.link <= LK_OPEN_BR;
    end else if (adv) begin
      ctl <= ctl_next;
    end
  end

  // link spans, written only on the steps that capture them
  always_ff @(posedge clk) begin
    if (adv) begin
      if (span_we.text_first) begin
        text_first <= in_pos;
      end
      if (span_we.text_last) begin
        text_last <= in_pos;
      end
      if (span_we.url_first) begin
        url_first <= in_pos;
      end
      if (span_we.url_last) begin
        url_last <= in_pos;
      end
      if (span_we.link_after) begin
        link_after <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= adv || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mark   <= mark_next;
      resume_pos <= resume_pos_next;
      consumed   <= consumed_next;
    end
  end

  a_hold_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !adv) |-> (out_valid && out_stall))
    else $error("input item held while result register free");

  a_text_begin_enters_text: assert property (@(posedge clk) disable iff (rst)
    (adv && mark_next == MK_TEXT) |=> (ctl.link == LK_WR_TEXT && out_mark == MK_TEXT))
    else $error("text begin mark without text replay");

  a_link_end_rearms: assert property (@(posedge clk) disable iff (rst)
    (adv && mark_next == MK_END) |=> (ctl.link == LK_OPEN_BR && consumed))
    else $error("link end did not rearm detection");

endmodule

[tb/text_word_and_link_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// text_word_and_link_parser_top_tb
// Self-checking bench for the word splitter and [text](url) link parser
// ----------------------------------------------------------------------------
//  A small caller drives generated lines: it feeds the character at each
//  position and follows the resume position that the local parser model
//  predicts, so link detection, replay and rewinds are exercised in depth.
//  Random raw items and corrupted kinds or characters are mixed in. Both
//  handshakes idle in random bursts, and every accepted result is compared
//  field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module text_word_and_link_parser_top_tb import twlp_pkg::*;;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    mark_t       mark;
    logic [15:0] steer_pos;
    logic        done;
  } parse_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ch = 8'd0;
  logic [15:0] char_pos = 16'd0;
  logic [1:0]  char_kind = KIND_PLAIN;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  mark;
  logic [15:0] resume_pos;
  logic        consumed;

  // parser model state
  flow_t       flow_q = FL_OUT;
  link_t       link_q = LK_OPEN_BR;
  logic [15:0] text_lo = '0;
  logic [15:0] text_hi = '0;
  logic [15:0] url_lo = '0;
  logic [15:0] url_hi = '0;
  logic [15:0] after_link = '0;

  parse_res_t  pending_marks[$];
  logic [7:0]  line_buf[$];
  logic [15:0] next_feed;
  logic        idle_on = 1'b1;
  int          sent_items = 0;
  int          errors = 0;
  int          cycles = 0;
  int          stall_left = 0;

  text_word_and_link_parser_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .char_pos   (char_pos),
    .char_kind  (char_kind),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mark       (mark),
    .resume_pos (resume_pos),
    .consumed   (consumed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  task automatic predict_parse(input logic [7:0] c, input logic [15:0] p,
                               input logic [1:0] k, output parse_res_t r);
    logic word;
    logic drop;
    logic close_hit;
    r.mark = MK_NONE;
    r.steer_pos = p + 16'd1;
    r.done = 1'b1;
    word = !is_blank(c) && c != CH_LF;
    drop = 1'b0;
    close_hit = 1'b0;
    if (link_q != LK_OFF) begin
      r.done = 1'b0;
      if (k == KIND_FORCED) begin
        link_q = LK_OFF;
        r.steer_pos = p;
      end else if (k == KIND_END || c == CH_LF) begin
        drop = 1'b1;
      end else begin
        case (link_q)
          LK_OPEN_BR: begin
            if (c == CH_LBRACK) link_q = LK_TEXT;
            else drop = 1'b1;
          end
          LK_TEXT: begin
            if (!is_blank(c)) begin
              link_q = LK_CLOSE_BR;
              text_lo = p;
            end
          end
          LK_CLOSE_BR: begin
            if (c == CH_RBRACK) begin
              link_q = LK_OPEN_PAR;
              text_hi = p;
            end
          end
          LK_OPEN_PAR: begin
            if (c == CH_LPAREN) link_q = LK_URL;
            else drop = 1'b1;
          end
          LK_URL: begin
            if (!is_blank(c)) begin
              link_q = LK_URL_END;
              url_lo = p;
            end
          end
          LK_URL_END: begin
            if (c == CH_RPAREN) begin
              url_hi = p;
              close_hit = 1'b1;
            end else if (c == CH_SPACE) begin
              link_q = LK_CLOSE_PAR;
              url_hi = p;
            end
          end
          LK_CLOSE_PAR: begin
            if (c == CH_RPAREN) close_hit = 1'b1;
            else if (!is_blank(c)) drop = 1'b1;
          end
          LK_WR_URL: begin
            if (p == url_hi) begin
              r.mark = MK_TEXT;
              link_q = LK_WR_TEXT;
              r.steer_pos = text_lo;
            end else begin
              r.mark = MK_CHAR;
            end
          end
          LK_WR_TEXT: begin
            if (p == text_hi) begin
              r.mark = MK_END;
              link_q = LK_OPEN_BR;
              r.steer_pos = after_link;
              r.done = 1'b1;
            end else begin
              r.mark = MK_CHAR;
            end
          end
          default: ;
        endcase
      end
      if (drop) begin
        link_q = LK_OFF;
        r.steer_pos = '0;
      end
      // closing paren: enter the word flow first, then replay the url
      if (close_hit) begin
        if (flow_q == FL_OUT) begin
          flow_q = FL_IN;
          r.steer_pos = p;
        end else begin
          r.mark = (flow_q == FL_AFTER) ? MK_SPACE_URL : MK_URL;
          flow_q = FL_IN;
          link_q = LK_WR_URL;
          after_link = p + 16'd1;
          r.steer_pos = url_lo;
        end
      end
    end else if (k != KIND_END) begin
      if (flow_q == FL_IN) begin
        if (word) begin
          r.mark = MK_CHAR;
        end else begin
          flow_q = FL_AFTER;
          link_q = LK_OPEN_BR;
        end
      end else if (word) begin
        if (flow_q == FL_AFTER) r.mark = MK_SPACE;
        flow_q = FL_IN;
        r.done = 1'b0;
        r.steer_pos = p;
      end
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic [15:0] p, input logic [1:0] k);
    parse_res_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    ch        <= c;
    char_pos  <= p;
    char_kind <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_parse(c, p, k, r);
    pending_marks.push_back(r);
    next_feed = r.steer_pos;
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_marks.size() != 0) @(posedge clk);
  endtask

  // caller loop: feed line_buf from base, follow the predicted resume position
  task automatic run_line(input logic [15:0] base, input int cap, input int end_at,
                          input int noise_pct);
    int          step;
    logic        ended;
    logic [15:0] p;
    logic [15:0] off;
    logic [7:0]  c;
    logic [1:0]  k;
    step = 0;
    ended = 1'b0;
    p = base;
    while (!ended && step < cap) begin
      off = p - base;
      if (off < line_buf.size()) begin
        c = line_buf[off];
        k = KIND_PLAIN;
      end else begin
        c = 8'($urandom_range(0, 255));
        k = KIND_END;
      end
      if (step == end_at) k = KIND_END;
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 3))
          0: k = KIND_FORCED;
          1: k = KIND_END;
          2: c = CH_LF;
          default: begin
            c = 8'($urandom_range(0, 255));
            k = KIND_SPARE;
          end
        endcase
      end
      ended = (k == KIND_END);
      send_char(c, p, k);
      p = next_feed;
      step++;
    end
  endtask

  task automatic add_word();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
      else line_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
    end
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(1, 2)) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic build_line();
    line_buf.delete();
    if ($urandom_range(0, 3) == 0) add_blanks();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) != 0) begin
        line_buf.push_back(CH_LBRACK);
        if ($urandom_range(0, 2) == 0) add_blanks();
        add_word();
        if ($urandom_range(0, 3) == 0) add_blanks();
        line_buf.push_back(CH_RBRACK);
        line_buf.push_back(CH_LPAREN);
        if ($urandom_range(0, 2) == 0) add_blanks();
        add_word();
        if ($urandom_range(0, 2) == 0) line_buf.push_back(CH_SPACE);
        if ($urandom_range(0, 3) == 0) add_blanks();
        line_buf.push_back(CH_RPAREN);
      end else begin
        add_word();
      end
      if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_LF);
      else add_blanks();
    end
    // broken link syntax now and then
    if ($urandom_range(0, 4) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(32, 126));
  endtask

  task automatic set_line(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic test_link_replay();
    idle_on = 1'b0;
    // first close paren outside a word, then url and text replay
    set_line("[a](b)");
    run_line(16'd0, 20, -1, 0);
    // link after a blank run, cut off by end of input while the url is scanned
    set_line("x [a](b)");
    run_line(16'd0, 20, 8, 0);
  endtask

  task automatic test_field_extremes();
    idle_on = 1'b1;
    send_char(8'hFF, 16'hFFFF, KIND_SPARE);
    send_char(8'h00, 16'h0000, KIND_END);
    send_char(8'h41, 16'h8000, KIND_FORCED);
    send_char(CH_TAB, 16'h7FFF, KIND_PLAIN);
    send_char(CH_LBRACK, 16'h1234, KIND_PLAIN);
    send_char(8'h61, 16'h1235, KIND_FORCED);
  endtask

  task automatic test_random_lines();
    logic [15:0] base;
    while (sent_items < 1000) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          send_char(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    2'($urandom_range(0, 3)));
      end
      build_line();
      base = ($urandom_range(0, 9) == 0) ? 16'hFFFF - 16'($urandom_range(0, 12)) : 16'd0;
      run_line(base, 4 * line_buf.size() + 10, -1, 4);
    end
  endtask

  task automatic test_drain_pause();
    idle_on = 1'b1;
    wait_drained();
    build_line();
    run_line(16'd0, 4 * line_buf.size() + 10, -1, 0);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    while (sent_items < 1130) begin
      build_line();
      run_line(16'd0, 4 * line_buf.size() + 10, -1, 2);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    parse_res_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_marks.size() == 0) begin
        $display("%0t result with no item pending: mark %0d resume_pos %0d consumed %0d",
                 $time, mark, resume_pos, consumed);
        errors++;
      end else begin
        exp_r = pending_marks.pop_front();
        if (mark !== exp_r.mark) begin
          $display("%0t mark: expected %0d actual %0d", $time, exp_r.mark, mark);
          errors++;
        end
        if (resume_pos !== exp_r.steer_pos) begin
          $display("%0t resume_pos: expected %0d actual %0d", $time, exp_r.steer_pos,
                   resume_pos);
          errors++;
        end
        if (consumed !== exp_r.done) begin
          $display("%0t consumed: expected %0d actual %0d", $time, exp_r.done, consumed);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_link_replay();
    test_field_extremes();
    test_random_lines();
    test_drain_pause();
    test_steady_stream();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
